// ===== hw/rtl/egcd_pkg.sv =====
// ---------------------------------------------------------------------------
// egcd_pkg
// Shared widths, payload structs, controller states and the command/status
// bundles between the extended gcd controller and its datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package egcd_pkg;

  localparam int OP_W  = 32;        // signed operand width
  localparam int RES_W = OP_W - 1;  // divisor / inverse width
  localparam int MAG_W = OP_W;      // magnitude width (holds 2^(OP_W-1))
  localparam int CW    = OP_W + 2;  // coefficient width, two's complement
  localparam int DW    = OP_W + 2;  // divider width
  localparam int CNT_W = $clog2(DW);

  typedef struct packed {
    logic                    mode;
    logic signed [OP_W-1:0]  operand_a;
    logic signed [OP_W-1:0]  operand_b;
  } in_item_t;

  typedef struct packed {
    logic [RES_W-1:0]        divisor;
    logic signed [OP_W-1:0]  coef_u;
    logic signed [OP_W-1:0]  coef_v;
    logic [RES_W-1:0]        inverse;
    logic                    error;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHK,
    ST_EDIV,
    ST_EUPD,
    ST_UDIV,
    ST_USAVE,
    ST_VDIV,
    ST_VSAVE,
    ST_NDIV,
    ST_NUPD,
    ST_FIN
  } state_t;

  typedef enum logic [1:0] {
    SEL_EUCLID,
    SEL_STEPU,
    SEL_STEPV,
    SEL_NORM
  } div_sel_t;

  typedef struct packed {
    logic     load;       // capture a new item
    logic     div_load;   // set up the divider
    div_sel_t div_sel;
    logic     div_step;   // one quotient bit
    logic     euc_upd;    // apply one Euclid round
    logic     save_stepu;
    logic     save_stepv;
    logic     norm_upd;   // fold the normalization back into u, v
    logic     out_load;   // fill the result register
  } cmd_t;

  typedef struct packed {
    logic loop_done;      // x == y or y == 0
    logic mb_zero;        // |b| == 0, no normalization
    logic div_last;       // divider on its final bit
  } sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/egcd_ctrl.sv =====
// ---------------------------------------------------------------------------
// egcd_ctrl
// Sequencer: Euclid rounds, step divisions, normalization, result handoff.
// ---------------------------------------------------------------------------
`default_nettype none

module egcd_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  wire              out_ready,
  input  egcd_pkg::sts_t   sts,
  output egcd_pkg::cmd_t   cmd
);
  import egcd_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.div_sel = SEL_EUCLID;
    in_ready  = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        cmd.div_load = 1'b1;
        if (!sts.loop_done) begin
          cmd.div_sel = SEL_EUCLID;
          state_nxt   = ST_EDIV;
        end else if (sts.mb_zero) begin
          cmd.div_load = 1'b0;
          state_nxt    = ST_FIN;
        end else begin
          cmd.div_sel = SEL_STEPU;
          state_nxt   = ST_UDIV;
        end
      end
      ST_EDIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = ST_EUPD;
      end
      ST_EUPD: begin
        cmd.euc_upd = 1'b1;
        state_nxt   = ST_CHK;
      end
      ST_UDIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = ST_USAVE;
      end
      ST_USAVE: begin
        cmd.save_stepu = 1'b1;
        cmd.div_load   = 1'b1;
        cmd.div_sel    = SEL_STEPV;
        state_nxt      = ST_VDIV;
      end
      ST_VDIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = ST_VSAVE;
      end
      ST_VSAVE: begin
        cmd.save_stepv = 1'b1;
        cmd.div_load   = 1'b1;
        cmd.div_sel    = SEL_NORM;
        state_nxt      = ST_NDIV;
      end
      ST_NDIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = ST_NUPD;
      end
      ST_NUPD: begin
        cmd.norm_upd = 1'b1;
        state_nxt    = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/egcd_dp.sv =====
// ---------------------------------------------------------------------------
// egcd_dp
// Operand registers, Bezout coefficients, radix-2 restoring divider with
// quotient-times-multiplicand accumulators, and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module egcd_dp (
  input  wire                  clk,
  input  egcd_pkg::in_item_t   in_data,
  input  egcd_pkg::cmd_t       cmd,
  output egcd_pkg::sts_t       sts,
  output egcd_pkg::out_item_t  out_data
);
  import egcd_pkg::*;

  // item and Euclid state
  logic             mode_r, neg_a_r, neg_b_r;
  logic [MAG_W-1:0] ma_r, mb_r, x_r, y_r;
  logic [CW-1:0]    cu_r, cv_r, nu_r, nv_r;
  logic [CW-1:0]    stepu_r;
  // divider
  logic [DW-1:0]    dvd_r, rem_r, dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CW-1:0]    acc_u_r, acc_v_r, mul_u_r, mul_v_r;
  out_item_t        out_r;

  logic [MAG_W-1:0] ma_in, mb_in;
  logic [DW:0]      rem_sh, rem_diff;
  logic             ge;
  logic             cu_pos;
  logic [DW-1:0]    norm_n;
  logic [CW-1:0]    u_fin, v_fin, inv_sum;
  logic             err_fin;

  assign ma_in = in_data.operand_a[OP_W-1] ? MAG_W'(-in_data.operand_a)
                                           : MAG_W'(in_data.operand_a);
  assign mb_in = in_data.operand_b[OP_W-1] ? MAG_W'(-in_data.operand_b)
                                           : MAG_W'(in_data.operand_b);

  assign rem_sh   = {rem_r, dvd_r[DW-1]};
  assign rem_diff = rem_sh - {1'b0, dvs_r};
  assign ge       = !rem_diff[DW];

  assign cu_pos = !cu_r[CW-1] && (cu_r != '0);
  assign norm_n = cu_pos ? DW'(cu_r - CW'(1)) : DW'(stepu_r - cu_r);

  assign sts.loop_done = (x_r == y_r) || (y_r == '0);
  assign sts.mb_zero   = (mb_r == '0);
  assign sts.div_last  = (cnt_r == CNT_W'(DW - 1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r  <= in_data.mode;
      neg_a_r <= in_data.operand_a[OP_W-1];
      neg_b_r <= in_data.operand_b[OP_W-1];
      ma_r    <= ma_in;
      mb_r    <= mb_in;
      x_r     <= ma_in;
      y_r     <= mb_in;
      cu_r    <= CW'(1);
      cv_r    <= '0;
      nu_r    <= '0;
      nv_r    <= CW'(1);
    end
    if (cmd.div_load) begin
      rem_r   <= '0;
      cnt_r   <= '0;
      acc_u_r <= '0;
      acc_v_r <= '0;
      case (cmd.div_sel)
        SEL_EUCLID: begin
          dvd_r   <= DW'(x_r);
          dvs_r   <= DW'(y_r);
          mul_u_r <= nu_r;
          mul_v_r <= nv_r;
        end
        SEL_STEPU: begin
          dvd_r   <= DW'(mb_r);
          dvs_r   <= DW'(x_r);
          mul_u_r <= '0;
          mul_v_r <= '0;
        end
        SEL_STEPV: begin
          dvd_r   <= DW'(ma_r);
          dvs_r   <= DW'(x_r);
          mul_u_r <= '0;
          mul_v_r <= '0;
        end
        SEL_NORM: begin
          dvd_r   <= norm_n;
          dvs_r   <= DW'(stepu_r);
          mul_u_r <= stepu_r;
        end
        default: begin
          dvd_r   <= '0;
          dvs_r   <= '0;
          mul_u_r <= '0;
          mul_v_r <= '0;
        end
      endcase
    end
    if (cmd.div_step) begin
      rem_r   <= ge ? rem_diff[DW-1:0] : rem_sh[DW-1:0];
      dvd_r   <= {dvd_r[DW-2:0], ge};
      cnt_r   <= cnt_r + CNT_W'(1);
      acc_u_r <= {acc_u_r[CW-2:0], 1'b0} + (ge ? mul_u_r : '0);
      acc_v_r <= {acc_v_r[CW-2:0], 1'b0} + (ge ? mul_v_r : '0);
    end
    if (cmd.euc_upd) begin
      x_r  <= y_r;
      y_r  <= MAG_W'(rem_r);
      cu_r <= nu_r;
      cv_r <= nv_r;
      nu_r <= cu_r - acc_u_r;
      nv_r <= cv_r - acc_v_r;
    end
    if (cmd.save_stepu) stepu_r <= CW'(dvd_r);
    if (cmd.save_stepv) mul_v_r <= CW'(dvd_r);  // step_v quotient just finished
    if (cmd.norm_upd) begin
      if (cu_pos) begin
        cu_r <= cu_r - acc_u_r;
        cv_r <= cv_r + acc_v_r;
      end else begin
        cu_r <= cu_r + acc_u_r;
        cv_r <= cv_r - acc_v_r;
      end
    end
    if (cmd.out_load) out_r <= '{divisor: x_r[RES_W-1:0], coef_u: u_fin[OP_W-1:0],
                                 coef_v: v_fin[OP_W-1:0],
                                 inverse: (mode_r && !err_fin && ma_r != MAG_W'(1))
                                          ? inv_sum[RES_W-1:0] : '0,
                                 error: err_fin};
  end

  // sign application; a zero operand zeroes its coefficient
  assign u_fin   = (ma_r == '0) ? '0 : (neg_a_r ? -cu_r : cu_r);
  assign v_fin   = (mb_r == '0) ? '0 : (neg_b_r ? -cv_r : cv_r);
  assign inv_sum = v_fin + CW'(ma_r);
  assign err_fin = mode_r && (neg_a_r || neg_b_r || x_r != MAG_W'(1));

  assign out_data = out_r;

endmodule

`default_nettype wire

// ===== hw/rtl/extended_gcd_with_inverse.sv =====
// ---------------------------------------------------------------------------
// extended_gcd_with_inverse
// Extended Euclid (gcd, Bezout coefficients) and modular inverse engine.
// ---------------------------------------------------------------------------
// One item in, one result out. Mode 0 returns gcd(|a|,|b|) and coefficients
// u, v with u*|a| + v*|b| = d, u normalized into 1..|b|/d (u=1, v=0 when
// b is zero), then signed by sign(a) and sign(b). Mode 1 also returns the
// inverse of b mod a as v + a (0 for a modulus of 1) and flags an error for
// a negative operand or a gcd other than 1. All division runs through one
// radix-2 restoring divider, one quotient bit per cycle, which also
// accumulates quotient times coefficient. An item is captured, then runs
// Euclid rounds, each a division and an update followed by a check, then
// the three normalization divisions (skipped when b is zero), then the
// result handoff. A new item is taken while the previous result still
// waits in the output register; the next result waits in FIN until that
// register is free.
// ---------------------------------------------------------------------------
`default_nettype none

module extended_gcd_with_inverse (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  egcd_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output egcd_pkg::out_item_t  out_data
);
  import egcd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  egcd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // arithmetic and result register
  egcd_dp u_dp (
    .clk      (clk),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the extended gcd / modular inverse engine: a
// table of directed operands, then random transfers, checked against
// typed-in results or a bit-accurate gcd and Bezout predictor, under
// random idling on both sides and one long receiver hold-off.
// ---------------------------------------------------------------------------
module testbench;
  import egcd_pkg::*;

  localparam int  N_RANDOM    = 350;
  localparam int  HOLD_CYCLES = 6000;    // long receiver hold-off
  localparam int  DRAIN_WAIT  = 2000;
  localparam longint LIMIT    = 3000000;

  typedef struct {
    in_item_t  item;
    bit        known;   // expected result typed in below
    out_item_t res;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  out_item_t pending_results[$];  // expected results, oldest first
  stim_row_t stim_tab[$];
  int        n_mismatch = 0;
  longint    cycle_cnt = 0;
  bit        quiet = 1'b0;        // no idling on either side
  bit        hold_req = 1'b0;     // ask the receiver for its long hold-off
  int        hold_left = 0;

  always #5 clk = ~clk;

  extended_gcd_with_inverse dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Euclid on the operand magnitudes, u normalized into 1..|b|/d, then the
  // operand signs applied. 64-bit arithmetic is exact at these widths.
  function automatic out_item_t gcd_bezout(in_item_t it);
    out_item_t r;
    logic [63:0] ma, mb, x, y, t;
    longint cu, cv, nu, nv, q, pu, pv, stp_u, stp_v, m, sa, sb, u, v, inv;
    bit neg_a, neg_b, err;
    neg_a = it.operand_a[OP_W-1];
    neg_b = it.operand_b[OP_W-1];
    ma = {32'b0, it.operand_a};
    mb = {32'b0, it.operand_b};
    if (neg_a) ma = (~ma + 64'd1) & 64'hFFFF_FFFF;
    if (neg_b) mb = (~mb + 64'd1) & 64'hFFFF_FFFF;
    sa = (ma == 0) ? 0 : (neg_a ? -1 : 1);
    sb = (mb == 0) ? 0 : (neg_b ? -1 : 1);
    x = ma; y = mb;
    cu = 1; cv = 0; nu = 0; nv = 1;
    while (x != y && y != 0) begin
      q  = longint'(x / y);
      pu = cu; pv = cv;
      cu = nu; cv = nv;
      nu = pu - q * nu;
      nv = pv - q * nv;
      t = x; x = y; y = t % y;
    end
    // bring u into 1..|b|/d
    if (mb != 0 && x != 0) begin
      stp_u = longint'(mb / x);
      stp_v = longint'(ma / x);
      if (cu > 0) m = -((cu - 1) / stp_u);
      else        m = (stp_u - cu) / stp_u;
      cu = cu + m * stp_u;
      cv = cv - m * stp_v;
    end
    u = cu * sa;
    v = cv * sb;
    inv = 0;
    err = 1'b0;
    if (it.mode) begin
      if (neg_a || neg_b || x != 1) err = 1'b1;
      else if (ma != 1)             inv = v + longint'(ma);
    end
    r.divisor = x[RES_W-1:0];
    r.coef_u  = u[OP_W-1:0];
    r.coef_v  = v[OP_W-1:0];
    r.inverse = inv[RES_W-1:0];
    r.error   = err;
    return r;
  endfunction

  function automatic void add_row(bit md, int a, int b, bit known = 0,
                                  out_item_t res = '0);
    stim_row_t row;
    row.item.mode = md;
    row.item.operand_a = a;
    row.item.operand_b = b;
    row.known = known;
    row.res = res;
    stim_tab.push_back(row);
  endfunction

  // random operand: full range, small, or a well-formed mode 1 pair
  function automatic in_item_t rand_item();
    in_item_t it;
    int sel;
    sel = $urandom_range(9);
    it.mode = 1'($urandom_range(1));
    if (sel < 4) begin
      it.operand_a = $urandom;
      it.operand_b = $urandom;
    end else if (sel < 7) begin
      it.operand_a = int'($urandom_range(2000)) - 1000;
      it.operand_b = int'($urandom_range(2000)) - 1000;
    end else begin
      it.mode = 1'b1;
      it.operand_a = (sel == 9) ? $urandom_range(32'h7FFF_FFFF, 2) : $urandom_range(5000, 2);
      it.operand_b = $urandom_range(it.operand_a - 1);
    end
    return it;
  endfunction

  // drive one item; valid stays up until the transfer
  task automatic send_item(in_item_t it, bit known, out_item_t res);
    while (!quiet && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(known ? res : gcd_bezout(it));
  endtask

  // Receiver: random stalls, a long hold-off on request, and the check
  // of each result transfer against the oldest expectation.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("unexpected result %p at cycle %0d", out_data, cycle_cnt);
      end else begin
        if (out_data !== pending_results[0]) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch at cycle %0d\n  expected %p\n  actual   %p",
                     cycle_cnt, pending_results[0], out_data);
        end
        void'(pending_results.pop_front());
      end
    end
    if (hold_req && hold_left == 0) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet || ($urandom_range(99) >= 23);
    end
  end

  initial begin
    int wait_cnt;
    // zero operands, b zero, equal operands: results read off directly
    add_row(0, 0, 0, 1, '{31'd0, 32'sd0, 32'sd0, 31'd0, 1'b0});
    add_row(0, 5, 0, 1, '{31'd5, 32'sd1, 32'sd0, 31'd0, 1'b0});
    add_row(0, -5, 0, 1, '{31'd5, -32'sd1, 32'sd0, 31'd0, 1'b0});
    add_row(0, 7, 7, 1, '{31'd7, 32'sd1, 32'sd0, 31'd0, 1'b0});
    // modulus of one: no error, inverse zero
    add_row(1, 1, 0, 1, '{31'd1, 32'sd1, 32'sd0, 31'd0, 1'b0});
    // modulus zero, value one: inverse is v + n = 1
    add_row(1, 0, 1, 1, '{31'd1, 32'sd0, 32'sd1, 31'd1, 1'b0});
    add_row(1, 0, 0);                        // gcd zero, error
    add_row(1, 13, 0);                       // gcd 13, error
    add_row(1, 10, 4);                       // gcd not one
    add_row(1, -7, 3);                       // negative modulus
    add_row(1, 7, -3);                       // negative value
    add_row(1, 7, 3);
    add_row(0, 32'h8000_0000, 32'h8000_0000);  // most negative, gcd wraps
    add_row(0, 32'h8000_0000, 1);
    add_row(0, 32'h7FFF_FFFF, 32'h7FFF_FFFE);
    add_row(0, 1836311903, 1134903170);        // longest Euclid chain
    add_row(0, -1836311903, -1134903170);
    add_row(1, 1836311903, 1134903170);
    add_row(1, 32'h7FFF_FFFF, 2);
    add_row(0, 0, -9);
    add_row(0, -12, -18);
    add_row(1, 32'h7FFF_FFFF, 32'h7FFF_FFFE);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_tab[i])
      send_item(stim_tab[i].item, stim_tab[i].known, stim_tab[i].res);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 40)  hold_req = 1'b1;           // let the block back up
      quiet = (i >= 150 && i < 220);
      send_item(rand_item(), 1'b0, '0);
    end
    in_valid <= 1'b0;
    quiet = 1'b0;

    wait_cnt = 0;
    while (pending_results.size() != 0 && wait_cnt < 200000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (DRAIN_WAIT) @(posedge clk);

    if (n_mismatch == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
